// ===== hdl/mqtd_pkg.sv =====
package mqtd_pkg;

    localparam int DEF_MAX_WORKERS = 8;
    localparam int DEF_QUEUE_DEPTH = 16;

    localparam int TASK_W = 16;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    // request codes
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // thread mask codes, the unused code routes like any thread
    localparam logic [1:0] MASK_ANY    = 2'd0;
    localparam logic [1:0] MASK_MAIN   = 2'd1;
    localparam logic [1:0] MASK_WORKER = 2'd2;

    // result status codes
    localparam logic [2:0] ST_PUSHED    = 3'd0;
    localparam logic [2:0] ST_POPPED    = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BADCALLER = 3'd4;

    // register index on the config port
    localparam logic [0:0] REG_WORKER_COUNT = 1'b0;
    localparam logic [3:0] WORKER_COUNT_RESET = 4'd1;

    typedef struct packed {
        logic              func;
        logic [3:0]        caller_thread;
        logic              high_priority;
        logic [1:0]        thread_mask;
        logic [TASK_W-1:0] task_handle;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [TASK_W-1:0] out_task;
        logic [3:0]        queue_used;
    } t_out_item;

endpackage

// ===== hdl/mqtd_store.sv =====
module mqtd_store #(
    parameter int DEPTH = 160,
    parameter int AW    = 8
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_addr,
    input  logic [mqtd_pkg::TASK_W-1:0] i_wdata,
    output logic [mqtd_pkg::TASK_W-1:0] o_rdata
);
    import mqtd_pkg::*;

    logic [TASK_W-1:0] r_mem [0:DEPTH-1];
    logic [TASK_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // read data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/mqtd_ctrl.sv =====
module mqtd_ctrl #(
    parameter int MAX_WORKERS = mqtd_pkg::DEF_MAX_WORKERS,
    parameter int QUEUE_DEPTH = mqtd_pkg::DEF_QUEUE_DEPTH,
    parameter int QW = 4,
    parameter int PW = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  mqtd_pkg::t_in_item          i_item,
    input  logic [3:0]                  i_worker_count,
    output mqtd_pkg::t_out_item         o_res,
    output logic                        o_pop,
    output logic                        o_mem_we,
    output logic                        o_mem_re,
    output logic [QW+PW-1:0]            o_mem_addr,
    output logic [mqtd_pkg::TASK_W-1:0] o_mem_wdata
);
    import mqtd_pkg::*;

    localparam int NQ  = MAX_WORKERS + 2;
    localparam int FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int WCW = $clog2(MAX_WORKERS + 1);
    localparam int CW  = (WCW > 4) ? WCW : 4;
    localparam int RW  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

    logic [PW-1:0] r_head [0:NQ-1];
    logic [PW-1:0] r_tail [0:NQ-1];
    logic [FW-1:0] r_fill [0:NQ-1];
    logic [RW-1:0] r_rr;

    logic [CW-1:0] w_wc_raw;
    logic [CW-1:0] w_wc;
    logic [CW-1:0] w_caller;
    logic          w_bad;
    logic [QW-1:0] w_caller_q;
    logic [RW-1:0] w_rr_idx;
    logic [RW-1:0] w_rr_next;
    logic          w_rr_adv;
    logic [QW-1:0] w_q;
    logic [FW-1:0] w_fill_q;
    logic [2:0]    w_status;
    logic [PW-1:0] w_head_q;
    logic [PW-1:0] w_tail_q;
    logic          w_do_push;
    logic          w_do_pop;

    // worker count clamped to 1..MAX_WORKERS
    assign w_wc_raw = CW'(i_worker_count);
    always_comb begin
        if (w_wc_raw == '0) begin
            w_wc = CW'(1);
        end else if (w_wc_raw > CW'(MAX_WORKERS)) begin
            w_wc = CW'(MAX_WORKERS);
        end else begin
            w_wc = w_wc_raw;
        end
    end

    assign w_caller   = CW'(i_item.caller_thread);
    assign w_bad      = w_caller > w_wc;
    assign w_caller_q = QW'(i_item.caller_thread) + QW'(1);

    // stale counter after a lowered worker count restarts at zero
    assign w_rr_idx  = (CW'(r_rr) >= w_wc) ? '0 : r_rr;
    assign w_rr_next = (CW'(w_rr_idx) + CW'(1) >= w_wc) ? '0 : w_rr_idx + RW'(1);

    // target queue
    always_comb begin
        w_q      = '0;
        w_rr_adv = 1'b0;
        if (w_bad) begin
            w_q = '0;
        end else if (i_item.func == FUNC_POP) begin
            w_q = (r_fill[0] != '0) ? '0 : w_caller_q;
        end else if (i_item.high_priority) begin
            w_q = '0;
        end else begin
            case (i_item.thread_mask)
                MASK_MAIN: begin
                    w_q = QW'(1);
                end
                MASK_WORKER: begin
                    if (i_item.caller_thread != '0) begin
                        w_q = w_caller_q;
                    end else begin
                        w_q      = QW'(w_rr_idx) + QW'(2);
                        w_rr_adv = 1'b1;
                    end
                end
                default: begin
                    w_q = w_caller_q;
                end
            endcase
        end
    end

    assign w_fill_q = r_fill[w_q];
    assign w_head_q = r_head[w_q];
    assign w_tail_q = r_tail[w_q];

    always_comb begin
        if (w_bad) begin
            w_status = ST_BADCALLER;
        end else if (i_item.func == FUNC_POP) begin
            w_status = (w_fill_q == '0) ? ST_EMPTY : ST_POPPED;
        end else begin
            w_status = (w_fill_q >= FW'(QUEUE_DEPTH)) ? ST_FULL : ST_PUSHED;
        end
    end

    assign w_do_push = i_go && (w_status == ST_PUSHED);
    assign w_do_pop  = i_go && (w_status == ST_POPPED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NQ; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_fill[i] <= '0;
            end
            r_rr <= '0;
        end else begin
            if (w_do_push) begin
                r_tail[w_q] <= (w_tail_q == PW'(QUEUE_DEPTH - 1)) ? '0 : w_tail_q + PW'(1);
                r_fill[w_q] <= w_fill_q + FW'(1);
            end
            if (w_do_pop) begin
                r_head[w_q] <= (w_head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : w_head_q + PW'(1);
                r_fill[w_q] <= w_fill_q - FW'(1);
            end
            // advances on a full push too
            if (i_go && w_rr_adv) begin
                r_rr <= w_rr_next;
            end
        end
    end

    assign o_res.status     = w_status;
    assign o_res.out_task   = '0;
    assign o_res.queue_used = 4'(w_q);
    assign o_pop            = w_status == ST_POPPED;

    assign o_mem_we    = w_do_push;
    assign o_mem_re    = w_do_pop;
    assign o_mem_addr  = {w_q, (w_do_push ? w_tail_q : w_head_q)};
    assign o_mem_wdata = i_item.task_handle;

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_pop |=> r_fill[$past(w_q)] == $past(w_fill_q) - FW'(1))
        else $error("fill not decremented after pop");

    a_push_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_push |=> r_fill[$past(w_q)] == $past(w_fill_q) + FW'(1))
        else $error("fill not incremented after push");

    a_prio_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_do_pop && (w_q != '0)) |-> (r_fill[0] == '0))
        else $error("caller queue served while priority queue holds tasks");

    a_bad_keeps_rr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && w_bad) |=> $stable(r_rr))
        else $error("round-robin moved on a rejected item");

endmodule

// ===== hdl/multi_queue_task_dispatcher.sv =====
// a result passes the dispatch stage, then the output stage; throughput: 1 item per cycle
// unless the output stalls; pointers and fill counts update at acceptance, the task
// store is read or written in that same cycle with its read data registered once
// reset (synchronous, active low): all queues empty, round-robin at zero, worker_count 1;
// the task store itself is not cleared, fill counts keep unwritten entries from being read
module multi_queue_task_dispatcher #(
    parameter int MAX_WORKERS = mqtd_pkg::DEF_MAX_WORKERS,
    parameter int QUEUE_DEPTH = mqtd_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // item input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  mqtd_pkg::t_in_item           i_in_data,
    // result output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output mqtd_pkg::t_out_item          o_out_data,
    // config port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mqtd_pkg::CFG_AW-1:0]  paddr,
    input  logic [mqtd_pkg::CFG_DW-1:0]  pwdata,
    output logic [mqtd_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready
);
    import mqtd_pkg::*;

    localparam int NQ        = MAX_WORKERS + 2;
    localparam int QW        = $clog2(NQ);
    localparam int PW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int AW        = QW + PW;
    // each queue owns a power-of-two slice of the store, addressed as {queue, slot}
    localparam int MEM_DEPTH = NQ * (2 ** PW);

    // config register
    logic [3:0] r_worker_count;
    logic       w_cfg_wr;

    // dispatch stage: decision of the accepted item, read data comes from the store
    logic      r_b_valid;
    t_out_item r_b_res;
    logic      r_b_pop;

    // output stage
    logic      r_c_valid;
    t_out_item r_c_item;

    logic              w_in_acc;
    logic              w_b_move;
    t_out_item         w_res;
    logic              w_pop;
    logic              w_mem_we;
    logic              w_mem_re;
    logic [AW-1:0]     w_mem_addr;
    logic [TASK_W-1:0] w_mem_wdata;
    logic [TASK_W-1:0] w_mem_rdata;

    // ---------------------------------------------------------------
    // config port: always ready, register decoded by word index
    // ---------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[CFG_AW-1:2] == REG_WORKER_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_worker_count <= WORKER_COUNT_RESET;
        end else if (w_cfg_wr) begin
            r_worker_count <= pwdata[3:0];
        end
    end

    assign prdata = (paddr[CFG_AW-1:2] == REG_WORKER_COUNT) ? CFG_DW'(r_worker_count) : '0;

    // ---------------------------------------------------------------
    // handshake: dispatch stage moves on whenever the output stage is
    // free or being emptied, so an item can enter while a result waits
    // ---------------------------------------------------------------
    assign w_b_move   = r_b_valid && (!r_c_valid || !i_out_stall);
    assign o_in_stall = r_b_valid && !w_b_move;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // routing, pointers and fill counts
    mqtd_ctrl #(
        .MAX_WORKERS (MAX_WORKERS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .QW          (QW),
        .PW          (PW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (w_in_acc),
        .i_item         (i_in_data),
        .i_worker_count (r_worker_count),
        .o_res          (w_res),
        .o_pop          (w_pop),
        .o_mem_we       (w_mem_we),
        .o_mem_re       (w_mem_re),
        .o_mem_addr     (w_mem_addr),
        .o_mem_wdata    (w_mem_wdata)
    );

    // task handle store, read data only changes on a pop that is accepted
    mqtd_store #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_re    (w_mem_re),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    // dispatch stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_b_valid <= 1'b1;
        end else if (w_b_move) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_b_res <= w_res;
            r_b_pop <= w_pop;
        end
    end

    // output stage, merges popped handle; zero for every other status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_b_move) begin
            r_c_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_c_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_move) begin
            r_c_item.status     <= r_b_res.status;
            r_c_item.queue_used <= r_b_res.queue_used;
            r_c_item.out_task   <= r_b_pop ? w_mem_rdata : '0;
        end
    end

    assign o_out_valid = r_c_valid;
    assign o_out_data  = r_c_item;

    a_task_only_popped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_b_move && !r_b_pop) |=> (r_c_item.out_task == '0))
        else $error("handle reported on a result that is not a pop");

    a_bad_queue_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && (r_b_res.status == ST_BADCALLER)) |-> (r_b_res.queue_used == '0))
        else $error("rejected item reports a queue");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !w_b_move) |=> (r_b_valid && $stable(r_b_res)))
        else $error("dispatch stage overwritten while held");

endmodule
